@@ hdl/i2cm_pkg.sv @@
package i2cm_pkg;

   // Request kinds as they arrive on req_tuser.
   localparam logic [2:0] REQ_TICK  = 3'd0;
   localparam logic [2:0] REQ_START = 3'd1;
   localparam logic [2:0] REQ_STOP  = 3'd2;
   localparam logic [2:0] REQ_WRITE = 3'd3;
   localparam logic [2:0] REQ_READ  = 3'd4;
   localparam logic [2:0] REQ_WACK  = 3'd5;

   localparam logic [7:0] ACK_POLL_LIMIT_RESET = 8'd250;
   localparam logic [3:0] BITS_PER_BYTE        = 4'd8;

   // Command being sequenced, one-hot.
   typedef enum logic [5:0] {
      CMD_IDLE  = 6'b000001,
      CMD_START = 6'b000010,
      CMD_STOP  = 6'b000100,
      CMD_WRITE = 6'b001000,
      CMD_READ  = 6'b010000,
      CMD_WACK  = 6'b100000
   } cmd_type;

   typedef struct packed {
      cmd_type    cmd;
      logic [2:0] step;
      logic [3:0] bit_count;
      logic [7:0] shift_reg;
      logic [7:0] poll_count;
      logic       ack_choice;
      logic       scl;
      logic       sda;
      logic       fail;
      logic [7:0] rx_hold;
   } seq_state_type;

   typedef struct packed {
      logic [2:0] req_type;
      logic [7:0] tx_byte;
      logic       send_ack;
      logic       sda_in;
   } req_item_type;

   typedef struct packed {
      logic       scl_level;
      logic       sda_level;
      logic       busy_res;
      logic       done_res;
      logic [7:0] rx_byte;
      logic       ack_failed;
   } rsp_item_type;

   localparam seq_state_type SEQ_STATE_RESET = '{
      cmd:        CMD_IDLE,
      step:       3'd0,
      bit_count:  4'd0,
      shift_reg:  8'd0,
      poll_count: 8'd0,
      ack_choice: 1'b0,
      scl:        1'b1,
      sda:        1'b1,
      fail:       1'b0,
      rx_hold:    8'd0
   };

endpackage

@@ hdl/i2cm_step.sv @@
module i2cm_step import i2cm_pkg::*; (
   input  seq_state_type cur,
   input  req_item_type  item,
   input  logic [7:0]    poll_limit,
   output seq_state_type nxt,
   output rsp_item_type  result
);

   logic       done;
   logic [3:0] bit_count_inc;
   logic [7:0] shift_tx;
   logic [7:0] shift_rx;

   assign bit_count_inc = cur.bit_count + 4'd1;
   assign shift_tx      = {cur.shift_reg[6:0], 1'b0};
   assign shift_rx      = {cur.shift_reg[6:0], item.sda_in};

   always_comb begin
      nxt  = cur;
      done = 1'b0;
      if (item.req_type == REQ_TICK) begin
         unique case (cur.cmd)
            CMD_IDLE: begin
            end
            CMD_START: begin
               if (cur.step == 3'd0) begin
                  nxt.sda  = 1'b0;
                  nxt.step = 3'd1;
               end else if (cur.step == 3'd1) begin
                  nxt.scl  = 1'b0;
                  nxt.step = 3'd2;
               end else begin
                  done = 1'b1;
               end
            end
            CMD_STOP: begin
               if (cur.step == 3'd0) begin
                  nxt.scl  = 1'b1;
                  nxt.step = 3'd1;
               end else if (cur.step == 3'd1) begin
                  nxt.sda  = 1'b1;
                  nxt.step = 3'd2;
               end else begin
                  done = 1'b1;
               end
            end
            CMD_WRITE: begin
               if (cur.step == 3'd0) begin
                  nxt.scl  = 1'b1;
                  nxt.step = 3'd1;
               end else begin
                  nxt.scl       = 1'b0;
                  nxt.shift_reg = shift_tx;
                  nxt.bit_count = bit_count_inc;
                  if (bit_count_inc >= BITS_PER_BYTE) begin
                     nxt.sda = 1'b1;
                     done    = 1'b1;
                  end else begin
                     nxt.sda  = shift_tx[7];
                     nxt.step = 3'd0;
                  end
               end
            end
            CMD_READ: begin
               case (cur.step)
                  3'd0: begin
                     nxt.shift_reg = shift_rx;
                     nxt.scl       = 1'b0;
                     nxt.bit_count = bit_count_inc;
                     if (bit_count_inc >= BITS_PER_BYTE) nxt.rx_hold = shift_rx;
                     nxt.step      = 3'd1;
                  end
                  3'd1: begin
                     if (cur.bit_count < BITS_PER_BYTE) begin
                        nxt.scl  = 1'b1;
                        nxt.step = 3'd0;
                     end else begin
                        nxt.sda  = ~cur.ack_choice;
                        nxt.step = 3'd2;
                     end
                  end
                  3'd2: begin
                     nxt.scl  = 1'b1;
                     nxt.step = 3'd3;
                  end
                  3'd3: begin
                     nxt.scl  = 1'b0;
                     nxt.step = 3'd4;
                  end
                  3'd4: begin
                     // After an ACK the line is released for one more period.
                     if (cur.ack_choice) begin
                        nxt.sda  = 1'b1;
                        nxt.step = 3'd5;
                     end else begin
                        done = 1'b1;
                     end
                  end
                  default: done = 1'b1;
               endcase
            end
            CMD_WACK: begin
               case (cur.step)
                  3'd0: begin
                     nxt.scl  = 1'b1;
                     nxt.step = 3'd1;
                  end
                  3'd1: begin
                     if (!item.sda_in) begin
                        nxt.scl  = 1'b0;
                        nxt.step = 3'd2;
                     end else if (cur.poll_count >= poll_limit) begin
                        // Timed out: run a stop sequence before finishing.
                        nxt.fail = 1'b1;
                        nxt.sda  = 1'b0;
                        nxt.step = 3'd3;
                     end else begin
                        nxt.poll_count = cur.poll_count + 8'd1;
                     end
                  end
                  3'd3: begin
                     nxt.scl  = 1'b1;
                     nxt.step = 3'd4;
                  end
                  3'd4: begin
                     nxt.sda  = 1'b1;
                     nxt.step = 3'd5;
                  end
                  3'd5: begin
                     nxt.scl  = 1'b0;
                     nxt.step = 3'd2;
                  end
                  default: done = 1'b1;
               endcase
            end
            default: begin
            end
         endcase
         if (done) begin
            nxt.cmd  = CMD_IDLE;
            nxt.step = 3'd0;
         end
      end else if (cur.cmd == CMD_IDLE) begin
         nxt.step = 3'd0;
         unique case (item.req_type)
            REQ_START: begin
               nxt.cmd = CMD_START;
               nxt.sda = 1'b1;
               nxt.scl = 1'b1;
            end
            REQ_STOP: begin
               nxt.cmd = CMD_STOP;
               nxt.sda = 1'b0;
            end
            REQ_WRITE: begin
               nxt.cmd       = CMD_WRITE;
               nxt.shift_reg = item.tx_byte;
               nxt.bit_count = 4'd0;
               nxt.sda       = item.tx_byte[7];
            end
            REQ_READ: begin
               nxt.cmd        = CMD_READ;
               nxt.shift_reg  = 8'd0;
               nxt.bit_count  = 4'd0;
               nxt.ack_choice = item.send_ack;
               nxt.scl        = 1'b1;
            end
            REQ_WACK: begin
               nxt.cmd        = CMD_WACK;
               nxt.sda        = 1'b1;
               nxt.poll_count = 8'd0;
               nxt.fail       = 1'b0;
            end
            default: begin
               // Unused kinds leave the state untouched.
               nxt = cur;
            end
         endcase
      end
   end

   always_comb begin
      result.scl_level  = nxt.scl;
      result.sda_level  = nxt.sda;
      result.busy_res   = (nxt.cmd != CMD_IDLE);
      result.done_res   = done;
      result.rx_byte    = nxt.rx_hold;
      result.ack_failed = nxt.fail;
   end

endmodule

@@ hdl/i2c_master_bit_sequencer.sv @@
// I2C master bit sequencer. Each request item is either a command (start,
// stop, write byte, read byte with ACK or NACK, wait for ACK), taken only
// while no command is running, or a tick that stands for one bus delay period
// and advances the running command by one step. Every request item yields
// exactly one response item carrying the driven SCL and SDA levels, busy and
// done flags, the last received byte and the ACK timeout flag. An item is
// registered on entry, passes through one stage of sequencing logic and
// lands in the response register, so one item is taken per clock cycle while
// the response output is not stalled; a stalled response output holds back
// further items once the input register is also full. The ACK poll limit must
// be written through csr_wen/csr_wdata only while the block is idle; the
// block itself does not enforce this.
module i2c_master_bit_sequencer import i2cm_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_wen,
   input  logic [7:0]  csr_wdata,
   input  logic        req_tvalid,
   output logic        req_tready,
   // tx_byte [7:0], send_ack [8], sda_in [9], zero [15:10]
   input  logic [15:0] req_tdata,
   // req_type [2:0]
   input  logic [2:0]  req_tuser,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // scl_level [0], sda_level [1], busy_res [2], done_res [3],
   // rx_byte [11:4], ack_failed [12], zero [15:13]
   output logic [15:0] rsp_tdata
);

   logic          in_valid_ff, in_valid_in;
   req_item_type  in_item_ff, in_item_in;
   logic          out_valid_ff, out_valid_in;
   rsp_item_type  out_item_ff, out_item_in;
   seq_state_type state_ff, state_in;
   logic [7:0]    poll_limit_ff, poll_limit_in;

   seq_state_type state_next;
   rsp_item_type  result;
   logic          advance;
   logic          req_take;

   i2cm_step u_step (
      .cur        (state_ff),
      .item       (in_item_ff),
      .poll_limit (poll_limit_ff),
      .nxt        (state_next),
      .result     (result)
   );

   // The registered item moves on when the response register is free or emptying.
   assign advance    = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;
   assign req_take   = req_tvalid && req_tready;

   always_comb begin
      in_valid_in   = req_take || (in_valid_ff && !advance);
      in_item_in    = in_item_ff;
      if (req_take) begin
         in_item_in.req_type = req_tuser;
         in_item_in.tx_byte  = req_tdata[7:0];
         in_item_in.send_ack = req_tdata[8];
         in_item_in.sda_in   = req_tdata[9];
      end
      out_valid_in  = advance || (out_valid_ff && !rsp_tready);
      out_item_in   = advance ? result : out_item_ff;
      state_in      = advance ? state_next : state_ff;
      poll_limit_in = csr_wen ? csr_wdata : poll_limit_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff   <= 1'b0;
         out_valid_ff  <= 1'b0;
         state_ff      <= SEQ_STATE_RESET;
         poll_limit_ff <= ACK_POLL_LIMIT_RESET;
      end else begin
         in_valid_ff   <= in_valid_in;
         out_valid_ff  <= out_valid_in;
         state_ff      <= state_in;
         poll_limit_ff <= poll_limit_in;
      end
      in_item_ff  <= in_item_in;
      out_item_ff <= out_item_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {3'b000, out_item_ff.ack_failed, out_item_ff.rx_byte,
                        out_item_ff.done_res, out_item_ff.busy_res,
                        out_item_ff.sda_level, out_item_ff.scl_level};

endmodule

@@ hdl/i2cm_checker.sv @@
module i2cm_checker (
   input logic        clock,
   input logic        reset,
   input logic        csr_wen,
   input logic [7:0]  csr_wdata,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic [15:0] req_tdata,
   input logic [2:0]  req_tuser,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [15:0] rsp_tdata
);

   // A stalled response item stays put until it is taken.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("response item changed while stalled");

   // A command that finishes on an item cannot still be in progress.
   a_done_not_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !(rsp_tdata[3] && rsp_tdata[2]))
      else $error("done and busy together");

   // No response item is offered straight after reset.
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("response valid after reset");

   // With nothing entering and the output draining, the pipeline empties.
   a_drain: assert property (@(posedge clock) disable iff (reset)
      !req_tvalid && rsp_tready ##1 !req_tvalid && rsp_tready |=> !rsp_tvalid)
      else $error("response item appeared without a request");

endmodule

bind i2c_master_bit_sequencer i2cm_checker u_i2cm_checker (.*);
